/* hdl/prd_pkg.sv */
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants of the pulse rate detector: beat payloads,
// configuration register indexes and the fixed rate numerator.
// ----------------------------------------------------------------------------
package prd_pkg;

	// one minute in milliseconds, the dividend of every rate computation
	localparam logic [15:0] RATE_NUM = 16'd60000;
	// quotient bits produced by the divider, one per cycle
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD    = 3'd0,
		CFG_MIN_INTERVAL = 3'd1,
		CFG_MAX_INTERVAL = 3'd2,
		CFG_MIN_RATE     = 3'd3,
		CFG_MAX_RATE     = 3'd4
	} prd_cfg_idx_t;

	// register reset values
	localparam logic [11:0] THRESHOLD_RST    = 12'd1500;
	localparam logic [15:0] MIN_INTERVAL_RST = 16'd300;
	localparam logic [15:0] MAX_INTERVAL_RST = 16'd1500;
	localparam logic [15:0] MIN_RATE_RST     = 16'd55;
	localparam logic [15:0] MAX_RATE_RST     = 16'd105;

	typedef struct packed {
		logic [11:0] threshold;
		logic [15:0] min_interval_ms;
		logic [15:0] max_interval_ms;
		logic [15:0] min_rate;
		logic [15:0] max_rate;
	} prd_cfg_t;

	typedef struct packed {
		logic [11:0] sample;
		logic [31:0] now_ms;
	} prd_in_t;

	typedef struct packed {
		logic        beat;
		logic        rate_updated;
		logic        rate_report;
		logic [15:0] rate_bpm;
	} prd_out_t;

endpackage

/* hdl/pulse_rate_detector.sv */
// ----------------------------------------------------------------------------
// pulse_rate_detector
// Threshold-crossing heart rate detector with iterative rate division.
// ----------------------------------------------------------------------------
// Each input beat carries one sensor sample and its millisecond timestamp and
// yields exactly one result. A sample that does not record a beat, or records
// a beat whose interval lies outside the window, goes from accept through
// S_PUSH into the output register, and the next sample can be taken once
// S_PUSH has loaded it. For a beat with an interval inside the window, the
// rate 60000 / interval comes from a restoring divider that produces one
// quotient bit per cycle while the sequencer waits in S_DIV; S_DIV then hands
// the quotient over and S_PUSH loads the output register. in_ready is high
// only while the sequencer is idle; one finished result may wait in the output
// register while the next sample is taken, and the load of the next result
// waits in S_PUSH until the waiting result is taken.
// ----------------------------------------------------------------------------
module pulse_rate_detector import prd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  prd_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output prd_out_t             out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_PUSH
	} state_t;

	state_t      state_q;
	prd_cfg_t    cfg;
	logic [31:0] last_beat_q;
	logic        above_q;
	logic [15:0] rate_q;
	logic        beat_q;
	logic        upd_q;
	logic        report_q;
	logic        out_valid_q;
	prd_out_t    out_q;

	logic        accept;
	logic        beat_now;
	logic        below;
	logic [31:0] interval;
	logic        in_window;
	logic        div_start;
	logic        div_done;
	logic [15:0] div_quo;
	logic        out_free;
	logic        out_load;

	prd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// beat detection and interval window
	assign accept    = in_valid && in_ready;
	assign beat_now  = (in_data.sample > cfg.threshold) && !above_q;
	assign below     = in_data.sample < cfg.threshold;
	assign interval  = in_data.now_ms - last_beat_q;
	assign in_window = (interval > {16'd0, cfg.min_interval_ms})
		&& (interval < {16'd0, cfg.max_interval_ms});
	assign div_start = accept && beat_now && in_window;

	prd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (interval[15:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == S_PUSH) && out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer, detector state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_beat_q <= '0;
			above_q     <= 1'b0;
			rate_q      <= '0;
			beat_q      <= 1'b0;
			upd_q       <= 1'b0;
			report_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// output valid: set on a load, cleared when the result is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						beat_q   <= beat_now;
						upd_q    <= beat_now && in_window;
						report_q <= 1'b0;
						if (beat_now) begin
							last_beat_q <= in_data.now_ms;
							above_q     <= 1'b1;
						end else if (below) begin
							above_q <= 1'b0;
						end
						state_q <= div_start ? S_DIV : S_PUSH;
					end
				end
				S_DIV: begin
					if (div_done) begin
						rate_q   <= div_quo;
						report_q <= (div_quo >= cfg.min_rate) && (div_quo <= cfg.max_rate);
						state_q  <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (out_free) begin
						out_q.beat         <= beat_q;
						out_q.rate_updated <= upd_q;
						out_q.rate_report  <= report_q;
						out_q.rate_bpm     <= rate_q;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside division state");

	// a recorded beat disarms the detector
	a_beat_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && beat_now |=> above_q)
		else $error("detector still armed after a beat");

	// a report needs a recomputed rate, which needs a beat
	a_report_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.rate_report || out_data.rate_updated)
			&& (!out_data.rate_updated || out_data.beat))
		else $error("result flags inconsistent");

	// a waiting result stays put until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("waiting result changed or dropped");

endmodule

/* hdl/prd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// prd_cfg_regs
// Configuration register file: threshold, interval window and rate range,
// written one register per beat on the configuration channel.
// ----------------------------------------------------------------------------
module prd_cfg_regs import prd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output prd_cfg_t             cfg
);

	prd_cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg        = cfg_q;

	// register decode, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold       <= THRESHOLD_RST;
			cfg_q.min_interval_ms <= MIN_INTERVAL_RST;
			cfg_q.max_interval_ms <= MAX_INTERVAL_RST;
			cfg_q.min_rate        <= MIN_RATE_RST;
			cfg_q.max_rate        <= MAX_RATE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_THRESHOLD:    cfg_q.threshold       <= cfg_data[11:0];
				CFG_MIN_INTERVAL: cfg_q.min_interval_ms <= cfg_data;
				CFG_MAX_INTERVAL: cfg_q.max_interval_ms <= cfg_data;
				CFG_MIN_RATE:     cfg_q.min_rate        <= cfg_data;
				CFG_MAX_RATE:     cfg_q.max_rate        <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* hdl/prd_divider.sv */
// ----------------------------------------------------------------------------
// prd_divider
// Restoring radix-2 divider computing one minute in milliseconds divided by
// the beat interval, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prd_divider import prd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quotient
);

	logic [15:0]          rem_q;
	logic [15:0]          quo_q;
	logic [15:0]          dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	// trial subtraction of the shifted partial remainder
	assign trial = {rem_q, quo_q[15]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = !diff[16];

	assign done     = done_q;
	assign quotient = quo_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= RATE_NUM;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

endmodule
